/* rtl/raa_pkg.sv */
// Shared types, constants and codes for the rectangle area allocator.
package raa_pkg;

  localparam int MAX_FREE_DEF = 64;
  localparam int CRD_W        = 15;
  localparam int CFG_IDX_W    = 3;

  typedef logic [CRD_W-1:0]   crd_t;
  typedef logic [CRD_W:0]     crd_ext_t;
  typedef logic [2*CRD_W-1:0] area_t;

  localparam crd_t CRD_MAX  = '1;
  localparam crd_t BASE_RST = 15'd1024;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_W = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_H = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_W  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_H  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FAST   = 3'd4;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RESERVE = 1'b1;

  typedef struct packed {
    crd_t l;
    crd_t t;
    crd_t r;
    crd_t b;
  } rect_t;

  typedef enum logic [4:0] {
    ST_INIT, ST_IDLE, ST_SRCH_RD, ST_SRCH_EV, ST_SRCH_END, ST_GROW,
    ST_FAST_MOD, ST_FAST_PUSH, ST_SP_INIT, ST_KA_RD, ST_KA_EV, ST_KB_INIT,
    ST_KB_RD, ST_KB_EV, ST_SP_SWAP, ST_CL_INIT, ST_CL_XRD, ST_CL_XLD,
    ST_CL_YRD, ST_CL_YEV, ST_CL_XEND, ST_CL_SWAP, ST_FINISH
  } state_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_INIT, OP_START, OP_RD_I, OP_SRCH_EV, OP_SET_RES, OP_GROW,
    OP_FAST_MOD, OP_FAST_PUSH, OP_PASS_INIT, OP_KEEP, OP_IDX_CLR,
    OP_PUSH_STEP, OP_SWAP, OP_XLOAD, OP_RD_J, OP_CMP, OP_XEND, OP_FINISH
  } op_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic i_last;
    logic j_last;
    logic found;
    logic can_grow;
    logic fast;
    logic is_reserve;
    logic cut;
    logic ev_done;
    logic out_busy;
  } dp_stat_t;

endpackage

/* rtl/raa_ctrl.sv */
// Sequencer for search, growth, guillotine cut, split and cleanup passes of the allocator.
module raa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  raa_pkg::dp_stat_t stat,
  output raa_pkg::dp_cmd_t  cmd
);

  raa_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= raa_pkg::ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      raa_pkg::ST_INIT:      state_nxt = raa_pkg::ST_IDLE;
      raa_pkg::ST_IDLE:      if (in_valid) state_nxt = raa_pkg::ST_SRCH_RD;
      raa_pkg::ST_SRCH_RD:   state_nxt = stat.cnt_zero ? raa_pkg::ST_SRCH_END
                                                       : raa_pkg::ST_SRCH_EV;
      raa_pkg::ST_SRCH_EV:   state_nxt = stat.i_last ? raa_pkg::ST_SRCH_END
                                                     : raa_pkg::ST_SRCH_RD;
      raa_pkg::ST_SRCH_END: begin
        if (stat.is_reserve) begin
          state_nxt = stat.found ? raa_pkg::ST_SP_INIT : raa_pkg::ST_FINISH;
        end else if (stat.found) begin
          state_nxt = stat.fast ? raa_pkg::ST_FAST_MOD : raa_pkg::ST_SP_INIT;
        end else begin
          state_nxt = stat.can_grow ? raa_pkg::ST_GROW : raa_pkg::ST_FINISH;
        end
      end
      raa_pkg::ST_GROW:      state_nxt = raa_pkg::ST_SRCH_RD;
      raa_pkg::ST_FAST_MOD:  state_nxt = stat.cut ? raa_pkg::ST_FAST_PUSH
                                                  : raa_pkg::ST_FINISH;
      raa_pkg::ST_FAST_PUSH: state_nxt = raa_pkg::ST_FINISH;
      raa_pkg::ST_SP_INIT:   state_nxt = raa_pkg::ST_KA_RD;
      raa_pkg::ST_KA_RD:     state_nxt = raa_pkg::ST_KA_EV;
      raa_pkg::ST_KA_EV:     state_nxt = stat.i_last ? raa_pkg::ST_KB_INIT
                                                     : raa_pkg::ST_KA_RD;
      raa_pkg::ST_KB_INIT:   state_nxt = raa_pkg::ST_KB_RD;
      raa_pkg::ST_KB_RD:     state_nxt = raa_pkg::ST_KB_EV;
      raa_pkg::ST_KB_EV: begin
        if (stat.ev_done) begin
          state_nxt = stat.i_last ? raa_pkg::ST_SP_SWAP : raa_pkg::ST_KB_RD;
        end
      end
      raa_pkg::ST_SP_SWAP:   state_nxt = raa_pkg::ST_CL_INIT;
      raa_pkg::ST_CL_INIT:   state_nxt = stat.cnt_zero ? raa_pkg::ST_CL_SWAP
                                                       : raa_pkg::ST_CL_XRD;
      raa_pkg::ST_CL_XRD:    state_nxt = raa_pkg::ST_CL_XLD;
      raa_pkg::ST_CL_XLD:    state_nxt = raa_pkg::ST_CL_YRD;
      raa_pkg::ST_CL_YRD:    state_nxt = raa_pkg::ST_CL_YEV;
      raa_pkg::ST_CL_YEV:    state_nxt = stat.j_last ? raa_pkg::ST_CL_XEND
                                                     : raa_pkg::ST_CL_YRD;
      raa_pkg::ST_CL_XEND:   state_nxt = stat.i_last ? raa_pkg::ST_CL_SWAP
                                                     : raa_pkg::ST_CL_XRD;
      raa_pkg::ST_CL_SWAP:   state_nxt = raa_pkg::ST_FINISH;
      raa_pkg::ST_FINISH:    if (!stat.out_busy) state_nxt = raa_pkg::ST_IDLE;
      default:               state_nxt = raa_pkg::ST_INIT;
    endcase
  end

  // outputs
  always_comb begin
    cmd.op   = raa_pkg::OP_NOP;
    in_ready = 1'b0;
    case (state_r)
      raa_pkg::ST_INIT:      cmd.op = raa_pkg::OP_INIT;
      raa_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = raa_pkg::OP_START;
      end
      raa_pkg::ST_SRCH_RD:   if (!stat.cnt_zero) cmd.op = raa_pkg::OP_RD_I;
      raa_pkg::ST_SRCH_EV:   cmd.op = raa_pkg::OP_SRCH_EV;
      raa_pkg::ST_SRCH_END:  cmd.op = raa_pkg::OP_SET_RES;
      raa_pkg::ST_GROW:      cmd.op = raa_pkg::OP_GROW;
      raa_pkg::ST_FAST_MOD:  cmd.op = raa_pkg::OP_FAST_MOD;
      raa_pkg::ST_FAST_PUSH: cmd.op = raa_pkg::OP_FAST_PUSH;
      raa_pkg::ST_SP_INIT:   cmd.op = raa_pkg::OP_PASS_INIT;
      raa_pkg::ST_KA_RD:     cmd.op = raa_pkg::OP_RD_I;
      raa_pkg::ST_KA_EV:     cmd.op = raa_pkg::OP_KEEP;
      raa_pkg::ST_KB_INIT:   cmd.op = raa_pkg::OP_IDX_CLR;
      raa_pkg::ST_KB_RD:     cmd.op = raa_pkg::OP_RD_I;
      raa_pkg::ST_KB_EV:     cmd.op = raa_pkg::OP_PUSH_STEP;
      raa_pkg::ST_SP_SWAP:   cmd.op = raa_pkg::OP_SWAP;
      raa_pkg::ST_CL_INIT:   cmd.op = raa_pkg::OP_PASS_INIT;
      raa_pkg::ST_CL_XRD:    cmd.op = raa_pkg::OP_RD_I;
      raa_pkg::ST_CL_XLD:    cmd.op = raa_pkg::OP_XLOAD;
      raa_pkg::ST_CL_YRD:    cmd.op = raa_pkg::OP_RD_J;
      raa_pkg::ST_CL_YEV:    cmd.op = raa_pkg::OP_CMP;
      raa_pkg::ST_CL_XEND:   cmd.op = raa_pkg::OP_XEND;
      raa_pkg::ST_CL_SWAP:   cmd.op = raa_pkg::OP_SWAP;
      raa_pkg::ST_FINISH:    if (!stat.out_busy) cmd.op = raa_pkg::OP_FINISH;
      default:               cmd.op = raa_pkg::OP_NOP;
    endcase
  end

endmodule

/* rtl/raa_dpath.sv */
// Free list memory, scan counters, geometry compares and result register.
module raa_dpath #(
  parameter int MAX_FREE = raa_pkg::MAX_FREE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  raa_pkg::dp_cmd_t                cmd,
  output raa_pkg::dp_stat_t               stat,
  input  logic                            in_command,
  input  raa_pkg::crd_t                   in_req_width,
  input  raa_pkg::crd_t                   in_req_height,
  input  raa_pkg::crd_t                   in_req_left,
  input  raa_pkg::crd_t                   in_req_top,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_success,
  output raa_pkg::crd_t                   out_pos_x,
  output raa_pkg::crd_t                   out_pos_y,
  output logic                            out_lost_space,
  input  logic                            cfg_we,
  input  logic [raa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  raa_pkg::crd_t                   cfg_wdata
);

  localparam int IW    = $clog2(MAX_FREE);
  localparam int CW    = $clog2(MAX_FREE + 1);
  localparam int AW    = IW + 1;
  localparam int MEM_D = 2 ** AW;
  localparam logic [CW-1:0] MAXF_C = CW'(MAX_FREE);
  localparam logic [CW-1:0] ONE_C  = CW'(1);

  // two banks: passes copy from the source bank into the other one
  raa_pkg::rect_t mem [MEM_D];
  logic           wr_en;
  logic [AW-1:0]  wr_addr, rd_addr;
  raa_pkg::rect_t wr_data;
  logic           rd_en;
  raa_pkg::rect_t rd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  raa_pkg::crd_t  base_w_r, base_h_r, max_w_r, max_h_r;
  logic           fast_r;
  logic [CW-1:0]  cnt_r, cnt_nxt, mcnt_r, mcnt_nxt, wptr_r, wptr_nxt;
  logic [IW-1:0]  idx_r, idx_nxt, jdx_r, jdx_nxt, best_idx_r, best_idx_nxt;
  logic           bank_r, bank_nxt;
  raa_pkg::crd_t  cur_w_r, cur_w_nxt, cur_h_r, cur_h_nxt;
  logic           gwn_r, gwn_nxt, ovf_r, ovf_nxt, found_r, found_nxt;
  logic           keep_r, keep_nxt;
  logic [1:0]     sub_r, sub_nxt;
  logic           cmd_r;
  raa_pkg::crd_t  req_w_r, req_h_r;
  raa_pkg::rect_t best_r, best_nxt, e0_r, e0_nxt, x_r, x_nxt;
  raa_pkg::area_t best_area_r, best_area_nxt;
  raa_pkg::crd_t  res_l_r, res_l_nxt, res_t_r, res_t_nxt;
  raa_pkg::crd_ext_t res_r_r, res_r_nxt, res_b_r, res_b_nxt;
  logic           out_valid_r, out_succ_r;
  raa_pkg::crd_t  out_x_r, out_y_r;
  logic           out_lost_r;

  // geometry of the entry just read
  raa_pkg::crd_t  fw, fh, bh;
  raa_pkg::area_t area;
  logic           fits, holds_res, overlap, y_holds_x;
  raa_pkg::crd_t  new_w, new_h;
  logic [raa_pkg::CRD_W:0] dbl_w, dbl_h;
  logic           cut, can_grow, i_last, j_last;

  assign fw   = (rd_r.r >= rd_r.l) ? rd_r.r - rd_r.l : '0;
  assign fh   = (rd_r.b >= rd_r.t) ? rd_r.b - rd_r.t : '0;
  assign area = raa_pkg::area_t'(fw) * raa_pkg::area_t'(fh);
  assign fits = (fw >= req_w_r) && (fh >= req_h_r);

  assign holds_res = (res_l_r >= rd_r.l) && (res_t_r >= rd_r.t) &&
                     (res_r_r <= {1'b0, rd_r.r}) && (res_b_r <= {1'b0, rd_r.b}) &&
                     (res_l_r < rd_r.r) && (res_t_r < rd_r.b);

  assign overlap = (res_r_r > {1'b0, rd_r.l}) && (res_l_r < rd_r.r) &&
                   (res_b_r > {1'b0, rd_r.t}) && (res_t_r < rd_r.b);

  assign y_holds_x = (x_r.l >= rd_r.l) && (x_r.t >= rd_r.t) &&
                     (x_r.r <= rd_r.r) && (x_r.b <= rd_r.b);

  assign dbl_w = {cur_w_r, 1'b0};
  assign dbl_h = {cur_h_r, 1'b0};
  assign new_w = (dbl_w > {1'b0, raa_pkg::CRD_MAX}) ? raa_pkg::CRD_MAX
                                                    : dbl_w[raa_pkg::CRD_W-1:0];
  assign new_h = (dbl_h > {1'b0, raa_pkg::CRD_MAX}) ? raa_pkg::CRD_MAX
                                                    : dbl_h[raa_pkg::CRD_W-1:0];

  assign can_grow = (gwn_r && (cur_w_r != '0) && (cur_w_r < max_w_r)) ||
                    (!gwn_r && (cur_h_r != '0) && (cur_h_r < max_h_r));

  assign bh  = (best_r.b >= best_r.t) ? best_r.b - best_r.t : '0;
  assign cut = ({1'b0, bh} > {req_h_r, 1'b0}) || (req_h_r >= (cur_h_r >> 1));

  assign i_last = ((CW'(idx_r) + ONE_C) == cnt_r);
  assign j_last = ((CW'(jdx_r) + ONE_C) == cnt_r);

  always_comb begin
    stat.cnt_zero   = (cnt_r == '0);
    stat.i_last     = i_last;
    stat.j_last     = j_last;
    stat.found      = found_r;
    stat.can_grow   = can_grow;
    stat.fast       = fast_r;
    stat.is_reserve = (cmd_r == raa_pkg::CMD_RESERVE);
    stat.cut        = cut;
    stat.ev_done    = !overlap || (sub_r == 2'd3);
    stat.out_busy   = out_valid_r && !out_ready;
  end

  // datapath micro-operations
  always_comb begin
    logic          push_c;
    raa_pkg::rect_t push_q;
    raa_pkg::rect_t tmp;
    logic          inc, dec;
    cnt_nxt       = cnt_r;
    mcnt_nxt      = mcnt_r;
    wptr_nxt      = wptr_r;
    idx_nxt       = idx_r;
    jdx_nxt       = jdx_r;
    best_idx_nxt  = best_idx_r;
    bank_nxt      = bank_r;
    cur_w_nxt     = cur_w_r;
    cur_h_nxt     = cur_h_r;
    gwn_nxt       = gwn_r;
    ovf_nxt       = ovf_r;
    found_nxt     = found_r;
    keep_nxt      = keep_r;
    sub_nxt       = sub_r;
    best_nxt      = best_r;
    best_area_nxt = best_area_r;
    e0_nxt        = e0_r;
    x_nxt         = x_r;
    res_l_nxt     = res_l_r;
    res_t_nxt     = res_t_r;
    res_r_nxt     = res_r_r;
    res_b_nxt     = res_b_r;
    wr_en         = 1'b0;
    wr_addr       = {bank_r, idx_r};
    wr_data       = rd_r;
    rd_en         = 1'b0;
    rd_addr       = {bank_r, idx_r};
    push_c        = 1'b0;
    push_q        = rd_r;
    tmp           = rd_r;
    inc           = 1'b0;
    dec           = 1'b0;
    case (cmd.op)
      raa_pkg::OP_INIT: begin
        wr_en   = 1'b1;
        wr_addr = {bank_r, IW'(0)};
        wr_data = '{l: '0, t: '0, r: base_w_r, b: base_h_r};
      end
      raa_pkg::OP_START: begin
        idx_nxt   = '0;
        found_nxt = 1'b0;
        res_l_nxt = in_req_left;
        res_t_nxt = in_req_top;
        res_r_nxt = {1'b0, in_req_left} + {1'b0, in_req_width};
        res_b_nxt = {1'b0, in_req_top} + {1'b0, in_req_height};
      end
      raa_pkg::OP_RD_I: begin
        rd_en = 1'b1;
      end
      raa_pkg::OP_RD_J: begin
        rd_en   = 1'b1;
        rd_addr = {bank_r, jdx_r};
      end
      raa_pkg::OP_SRCH_EV: begin
        if (idx_r == '0) e0_nxt = rd_r;
        if (cmd_r == raa_pkg::CMD_ALLOC) begin
          if (fits && (!found_r || (area < best_area_r))) begin
            found_nxt     = 1'b1;
            best_nxt      = rd_r;
            best_area_nxt = area;
            best_idx_nxt  = idx_r;
          end
        end else if (holds_res) begin
          found_nxt = 1'b1;
        end
        idx_nxt = idx_r + IW'(1);
      end
      raa_pkg::OP_SET_RES: begin
        if (cmd_r == raa_pkg::CMD_ALLOC) begin
          res_l_nxt = best_r.l;
          res_t_nxt = best_r.t;
          res_r_nxt = {1'b0, best_r.l} + {1'b0, req_w_r};
          res_b_nxt = {1'b0, best_r.t} + {1'b0, req_h_r};
        end
      end
      raa_pkg::OP_GROW: begin
        idx_nxt   = '0;
        found_nxt = 1'b0;
        gwn_nxt   = !gwn_r;
        if (gwn_r) begin
          cur_w_nxt = new_w;
          if ((cnt_r == ONE_C) &&
              (e0_r == raa_pkg::rect_t'{l: '0, t: '0, r: cur_w_r, b: cur_h_r})) begin
            tmp     = e0_r;
            tmp.r   = new_w;
            wr_en   = 1'b1;
            wr_addr = {bank_r, IW'(0)};
            wr_data = tmp;
          end else begin
            push_c = 1'b1;
            push_q = '{l: cur_w_r, t: '0, r: new_w, b: cur_h_r};
          end
        end else begin
          cur_h_nxt = new_h;
          if ((cnt_r == ONE_C) &&
              (e0_r == raa_pkg::rect_t'{l: '0, t: '0, r: cur_w_r, b: cur_h_r})) begin
            tmp     = e0_r;
            tmp.b   = new_h;
            wr_en   = 1'b1;
            wr_addr = {bank_r, IW'(0)};
            wr_data = tmp;
          end else begin
            push_c = 1'b1;
            push_q = '{l: '0, t: cur_h_r, r: cur_w_r, b: new_h};
          end
        end
      end
      raa_pkg::OP_FAST_MOD: begin
        tmp   = best_r;
        tmp.l = res_r_r[raa_pkg::CRD_W-1:0];
        if (cut) tmp.b = res_b_r[raa_pkg::CRD_W-1:0];
        wr_en   = 1'b1;
        wr_addr = {bank_r, best_idx_r};
        wr_data = tmp;
      end
      raa_pkg::OP_FAST_PUSH: begin
        push_c = 1'b1;
        push_q = '{l: res_l_r, t: res_b_r[raa_pkg::CRD_W-1:0], r: best_r.r, b: best_r.b};
      end
      raa_pkg::OP_PASS_INIT: begin
        idx_nxt  = '0;
        wptr_nxt = '0;
        mcnt_nxt = cnt_r;
      end
      raa_pkg::OP_KEEP: begin
        if (!overlap) begin
          wr_en    = 1'b1;
          wr_addr  = {!bank_r, wptr_r[IW-1:0]};
          wr_data  = rd_r;
          wptr_nxt = wptr_r + ONE_C;
        end
        idx_nxt = idx_r + IW'(1);
      end
      raa_pkg::OP_IDX_CLR: begin
        idx_nxt = '0;
        sub_nxt = '0;
      end
      raa_pkg::OP_PUSH_STEP: begin
        if (overlap) begin
          case (sub_r)
            2'd0: begin
              push_c = (res_r_r < {1'b0, rd_r.r});
              tmp.l  = res_r_r[raa_pkg::CRD_W-1:0];
            end
            2'd1: begin
              push_c = (res_l_r > rd_r.l);
              tmp.r  = res_l_r;
            end
            2'd2: begin
              push_c = (res_b_r < {1'b0, rd_r.b});
              tmp.t  = res_b_r[raa_pkg::CRD_W-1:0];
            end
            default: begin
              push_c = (res_t_r > rd_r.t);
              tmp.b  = res_t_r;
            end
          endcase
          if (push_c) begin
            if (mcnt_r < MAXF_C) begin
              wr_en    = 1'b1;
              wr_addr  = {!bank_r, wptr_r[IW-1:0]};
              wr_data  = tmp;
              wptr_nxt = wptr_r + ONE_C;
              inc      = 1'b1;
            end else begin
              ovf_nxt = 1'b1;
            end
          end
          dec      = (sub_r == 2'd3);
          mcnt_nxt = mcnt_r + CW'(inc) - CW'(dec);
          sub_nxt  = sub_r + 2'd1;
          push_c   = 1'b0;
        end
        if (!overlap || (sub_r == 2'd3)) begin
          idx_nxt = idx_r + IW'(1);
          sub_nxt = '0;
        end
      end
      raa_pkg::OP_SWAP: begin
        bank_nxt = !bank_r;
        cnt_nxt  = wptr_r;
      end
      raa_pkg::OP_XLOAD: begin
        x_nxt    = rd_r;
        keep_nxt = 1'b1;
        jdx_nxt  = '0;
      end
      raa_pkg::OP_CMP: begin
        // drop x under a strict container, or under a later identical entry
        if ((jdx_r != idx_r) && y_holds_x && ((rd_r != x_r) || (jdx_r > idx_r))) begin
          keep_nxt = 1'b0;
        end
        jdx_nxt = jdx_r + IW'(1);
      end
      raa_pkg::OP_XEND: begin
        if (keep_r) begin
          wr_en    = 1'b1;
          wr_addr  = {!bank_r, wptr_r[IW-1:0]};
          wr_data  = x_r;
          wptr_nxt = wptr_r + ONE_C;
        end
        idx_nxt = idx_r + IW'(1);
      end
      default: begin
      end
    endcase
    // append to the live list, or flag the loss when it is full
    if (push_c) begin
      if (cnt_r < MAXF_C) begin
        wr_en   = 1'b1;
        wr_addr = {bank_r, cnt_r[IW-1:0]};
        wr_data = push_q;
        cnt_nxt = cnt_r + ONE_C;
      end else begin
        ovf_nxt = 1'b1;
      end
    end
    // register write: reinitialize the list around the new base size
    if (cfg_we && (cfg_index <= raa_pkg::REG_FAST)) begin
      cnt_nxt   = ONE_C;
      gwn_nxt   = 1'b1;
      ovf_nxt   = 1'b0;
      cur_w_nxt = (cfg_index == raa_pkg::REG_BASE_W) ? cfg_wdata : base_w_r;
      cur_h_nxt = (cfg_index == raa_pkg::REG_BASE_H) ? cfg_wdata : base_h_r;
      wr_en     = 1'b1;
      wr_addr   = {bank_r, IW'(0)};
      wr_data   = '{l: '0, t: '0, r: cur_w_nxt, b: cur_h_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_w_r    <= raa_pkg::BASE_RST;
      base_h_r    <= raa_pkg::BASE_RST;
      max_w_r     <= raa_pkg::BASE_RST;
      max_h_r     <= raa_pkg::BASE_RST;
      fast_r      <= 1'b0;
      cnt_r       <= ONE_C;
      mcnt_r      <= '0;
      wptr_r      <= '0;
      idx_r       <= '0;
      jdx_r       <= '0;
      bank_r      <= 1'b0;
      cur_w_r     <= raa_pkg::BASE_RST;
      cur_h_r     <= raa_pkg::BASE_RST;
      gwn_r       <= 1'b1;
      ovf_r       <= 1'b0;
      found_r     <= 1'b0;
      keep_r      <= 1'b0;
      sub_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          raa_pkg::REG_BASE_W: base_w_r <= cfg_wdata;
          raa_pkg::REG_BASE_H: base_h_r <= cfg_wdata;
          raa_pkg::REG_MAX_W:  max_w_r  <= cfg_wdata;
          raa_pkg::REG_MAX_H:  max_h_r  <= cfg_wdata;
          raa_pkg::REG_FAST:   fast_r   <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
      cnt_r   <= cnt_nxt;
      mcnt_r  <= mcnt_nxt;
      wptr_r  <= wptr_nxt;
      idx_r   <= idx_nxt;
      jdx_r   <= jdx_nxt;
      bank_r  <= bank_nxt;
      cur_w_r <= cur_w_nxt;
      cur_h_r <= cur_h_nxt;
      gwn_r   <= gwn_nxt;
      ovf_r   <= ovf_nxt;
      found_r <= found_nxt;
      keep_r  <= keep_nxt;
      sub_r   <= sub_nxt;
      if (cmd.op == raa_pkg::OP_FINISH) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    best_idx_r  <= best_idx_nxt;
    best_r      <= best_nxt;
    best_area_r <= best_area_nxt;
    e0_r        <= e0_nxt;
    x_r         <= x_nxt;
    res_l_r     <= res_l_nxt;
    res_t_r     <= res_t_nxt;
    res_r_r     <= res_r_nxt;
    res_b_r     <= res_b_nxt;
    if (cmd.op == raa_pkg::OP_START) begin
      cmd_r   <= in_command;
      req_w_r <= in_req_width;
      req_h_r <= in_req_height;
    end
    if (cmd.op == raa_pkg::OP_FINISH) begin
      out_succ_r <= found_r;
      out_x_r    <= (found_r && (cmd_r == raa_pkg::CMD_ALLOC)) ? best_r.l : '0;
      out_y_r    <= (found_r && (cmd_r == raa_pkg::CMD_ALLOC)) ? best_r.t : '0;
      out_lost_r <= ovf_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_success    = out_succ_r;
  assign out_pos_x      = out_x_r;
  assign out_pos_y      = out_y_r;
  assign out_lost_space = out_lost_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAXF_C)
    else $error("free count above capacity");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r && !cfg_we |=> ovf_r)
    else $error("lost-space flag cleared without a register write");

  a_wptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wptr_r <= mcnt_r)
    else $error("copy pointer ran past the running list count");

  a_reserve_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == raa_pkg::OP_FINISH) && (cmd_r == raa_pkg::CMD_RESERVE)
      |=> (out_pos_x == '0) && (out_pos_y == '0))
    else $error("reserve reported a nonzero position");

endmodule

/* rtl/rect_area_allocator_unit.sv */
// Top level of the rectangle area allocator: controller, datapath and ports.
// Sequence: after the input transfer, one search pass over the free list, repeated after each
//   growth step, then the guillotine cut in fast mode, or the exact split pass over the overlapped
//   entries followed by the cleanup pass; then the result register loads, with out_valid rising
//   together with it, once the previous result has been taken.
// Throughput: one item at a time, the next transfer taken in the cycle after the result loads;
//   cleanup dominates. Reset: synchronous active-low.
module rect_area_allocator_unit #(
  parameter int MAX_FREE = raa_pkg::MAX_FREE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_command,
  input  raa_pkg::crd_t                 in_req_width,
  input  raa_pkg::crd_t                 in_req_height,
  input  raa_pkg::crd_t                 in_req_left,
  input  raa_pkg::crd_t                 in_req_top,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_success,
  output raa_pkg::crd_t                 out_pos_x,
  output raa_pkg::crd_t                 out_pos_y,
  output logic                          out_lost_space,
  input  logic                          cfg_we,
  input  logic [raa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  raa_pkg::crd_t                 cfg_wdata
);

  // Command from the sequencer to the datapath, status on the way back.
  raa_pkg::dp_cmd_t  dp_cmd;
  raa_pkg::dp_stat_t dp_stat;

  // Sequencer: walks the free list for the best fit or the containing area,
  // grows the atlas when an allocation fits nowhere, then runs the guillotine
  // cut or split and cleanup passes. It takes a new transfer only when idle.
  raa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (dp_stat),
    .cmd      (dp_cmd)
  );

  // Datapath: two-bank free list memory (each pass copies survivors into the
  // other bank), scan counters, geometry compares and the result register,
  // which holds a finished result until the output transfer completes.
  raa_dpath #(
    .MAX_FREE (MAX_FREE)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (dp_cmd),
    .stat           (dp_stat),
    .in_command     (in_command),
    .in_req_width   (in_req_width),
    .in_req_height  (in_req_height),
    .in_req_left    (in_req_left),
    .in_req_top     (in_req_top),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_success    (out_success),
    .out_pos_x      (out_pos_x),
    .out_pos_y      (out_pos_y),
    .out_lost_space (out_lost_space),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

endmodule
